@@ sv/fez_pkg.sv @@
package fez_pkg;

    localparam int PLANE_MAX_DEF = 16384;
    localparam int ROW_MAX_DEF   = 256;
    localparam int FRAC_BITS_DEF = 24;

    localparam int ROW_LEN_W   = 9;
    localparam int PLANE_LEN_W = 15;
    localparam int CFG_DATA_W  = 16;

    localparam logic [ROW_LEN_W-1:0]   ROW_LENGTH_RST   = 9'd64;
    localparam logic [PLANE_LEN_W-1:0] PLANE_LENGTH_RST = 15'd4096;

    // work queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        CFG_ROW_LENGTH   = 1'b0,
        CFG_PLANE_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] ez_old;
        logic signed [31:0] hx_here;
        logic signed [31:0] hy_here;
        logic signed [31:0] coef_keep;
        logic signed [31:0] coef_curl;
        logic signed [31:0] metric_x;
        logic signed [31:0] metric_y;
        logic               halo;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] ez_new;
        logic               saturated;
    } out_item_t;

    // one non-halo cell with its H differences already taken
    typedef struct packed {
        logic signed [31:0] ez_old;
        logic signed [31:0] coef_keep;
        logic signed [31:0] coef_curl;
        logic signed [31:0] metric_x;
        logic signed [31:0] metric_y;
        logic signed [32:0] dhy;
        logic signed [32:0] dhx;
    } work_item_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

endpackage

@@ sv/fez_front.sv @@
module fez_front
    import fez_pkg::*;
#(
    parameter int PLANE_MAX = PLANE_MAX_DEF,
    parameter int ROW_MAX   = ROW_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    input  logic [ROW_LEN_W-1:0]   row_length,
    input  logic [PLANE_LEN_W-1:0] plane_length,
    input  logic                   q_full,
    output logic                   q_push,
    output work_item_t             q_item
);

    localparam int RPW = $clog2(ROW_MAX);
    localparam int RLW = RPW + 1;
    localparam int RCW = (RLW > ROW_LEN_W) ? RLW : ROW_LEN_W;
    localparam int PPW = $clog2(PLANE_MAX);
    localparam int PLW = PPW + 1;
    localparam int PCW = (PLW > PLANE_LEN_W) ? PLW : PLANE_LEN_W;

    logic [31:0] hx_row_mem   [ROW_MAX];
    logic [31:0] hy_plane_mem [PLANE_MAX];

    logic [RPW-1:0] row_pos_reg, row_pos_next;
    logic [PPW-1:0] plane_pos_reg, plane_pos_next;
    logic           fs_valid_reg, fs_valid_next;
    in_item_t       fs_item_reg;
    logic signed [31:0] hx_prev_reg;
    logic signed [31:0] hy_prev_reg;

    logic           accept;
    logic           fs_move;
    logic [RCW-1:0] rlen_cfg;
    logic [PCW-1:0] plen_cfg;
    logic [RLW-1:0] rlen_eff;
    logic [PLW-1:0] plen_eff;
    logic [RLW-1:0] rpos_inc;
    logic [PLW-1:0] ppos_inc;

    // halo cells leave the front stage without needing queue room
    assign in_stall = fs_valid_reg && !fs_item_reg.halo && q_full;
    assign accept   = in_valid && !in_stall;
    assign fs_move  = fs_valid_reg && (fs_item_reg.halo || !q_full);
    assign q_push   = fs_valid_reg && !fs_item_reg.halo && !q_full;

    always_comb
    begin
        rlen_cfg = RCW'(row_length);
        plen_cfg = PCW'(plane_length);
        if (rlen_cfg == '0)
        begin
            rlen_eff = RLW'(1);
        end
        else if (rlen_cfg > RCW'(ROW_MAX))
        begin
            rlen_eff = RLW'(ROW_MAX);
        end
        else
        begin
            rlen_eff = RLW'(rlen_cfg);
        end
        if (plen_cfg == '0)
        begin
            plen_eff = PLW'(1);
        end
        else if (plen_cfg > PCW'(PLANE_MAX))
        begin
            plen_eff = PLW'(PLANE_MAX);
        end
        else
        begin
            plen_eff = PLW'(plen_cfg);
        end

        rpos_inc = {1'b0, row_pos_reg} + RLW'(1);
        ppos_inc = {1'b0, plane_pos_reg} + PLW'(1);
        row_pos_next   = row_pos_reg;
        plane_pos_next = plane_pos_reg;
        if (accept)
        begin
            row_pos_next   = (rpos_inc >= rlen_eff) ? '0 : rpos_inc[RPW-1:0];
            plane_pos_next = (ppos_inc >= plen_eff) ? '0 : ppos_inc[PPW-1:0];
        end

        if (accept)
        begin
            fs_valid_next = 1'b1;
        end
        else if (fs_move)
        begin
            fs_valid_next = 1'b0;
        end
        else
        begin
            fs_valid_next = fs_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg   <= '0;
            plane_pos_reg <= '0;
            fs_valid_reg  <= 1'b0;
        end
        else
        begin
            row_pos_reg   <= row_pos_next;
            plane_pos_reg <= plane_pos_next;
            fs_valid_reg  <= fs_valid_next;
        end
    end

    // read-first: the old neighbor comes out while the new value goes in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hx_prev_reg               <= hx_row_mem[row_pos_reg];
            hx_row_mem[row_pos_reg]   <= in_data.hx_here;
            hy_prev_reg               <= hy_plane_mem[plane_pos_reg];
            hy_plane_mem[plane_pos_reg] <= in_data.hy_here;
            fs_item_reg               <= in_data;
        end
    end

    always_comb
    begin
        q_item.ez_old    = fs_item_reg.ez_old;
        q_item.coef_keep = fs_item_reg.coef_keep;
        q_item.coef_curl = fs_item_reg.coef_curl;
        q_item.metric_x  = fs_item_reg.metric_x;
        q_item.metric_y  = fs_item_reg.metric_y;
        q_item.dhy       = 33'(fs_item_reg.hy_here) - 33'(hy_prev_reg);
        q_item.dhx       = 33'(fs_item_reg.hx_here) - 33'(hx_prev_reg);
    end

    a_row_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_pos_reg} < RLW'(ROW_MAX))
        else $error("row position beyond buffer");

    a_plane_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, plane_pos_reg} < PLW'(PLANE_MAX))
        else $error("plane position beyond buffer");

endmodule

@@ sv/fez_queue.sv @@
module fez_queue
    import fez_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  queue_wr_t  wr_in,
    output logic       full,
    input  work_item_t wr_item,
    input  logic       pop,
    output logic       empty,
    output work_item_t rd_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    work_item_t     slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_in.push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (wr_in.push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!wr_in.push && pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_in.push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_in.push |-> !wr_in.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_in.push && !pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count lost a transaction");

endmodule

@@ sv/fez_back.sv @@
module fez_back
    import fez_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  work_item_t q_item,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    localparam int PW = 65;              // metric times H difference
    localparam int RW = PW - FRAC_BITS;  // rounded curl term
    localparam int KW = 64 - FRAC_BITS;  // rounded keep/drive term
    localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [63:0]   HALF_K = 64'(1) << (FRAC_BITS - 1);

    logic en;

    // stage 1: curl products and keep product
    logic                 v1_reg;
    logic signed [PW-1:0] ptx_reg, pty_reg;
    logic signed [63:0]   pkeep1_reg;
    logic signed [31:0]   c2_1_reg;
    // stage 2: rounded terms
    logic                 v2_reg;
    logic signed [RW-1:0] tx_reg, ty_reg;
    logic signed [KW-1:0] keep2_reg;
    logic signed [31:0]   c2_2_reg;
    // stage 3: saturated curl
    logic                 v3_reg;
    logic signed [31:0]   curl_reg;
    logic                 clip3_reg;
    logic signed [KW-1:0] keep3_reg;
    logic signed [31:0]   c2_3_reg;
    // stage 4: drive product
    logic                 v4_reg;
    logic signed [63:0]   pdrive_reg;
    logic                 clip4_reg;
    logic signed [KW-1:0] keep4_reg;
    // stage 5: rounded drive
    logic                 v5_reg;
    logic signed [KW-1:0] drive_reg;
    logic                 clip5_reg;
    logic signed [KW-1:0] keep5_reg;
    // output register
    logic                 ov_reg;
    out_item_t            out_reg;

    logic signed [PW-1:0] ptx_next, pty_next, tx_sum, ty_sum;
    logic signed [63:0]   pkeep_next, keep_sum, pdrive_next, drive_sum;
    logic signed [RW:0]   curl_diff;
    logic [RW-31:0]       curl_hi;
    logic signed [31:0]   curl_next;
    logic                 curl_clip;
    logic signed [KW:0]   res_sum;
    logic [KW-31:0]       res_hi;
    out_item_t            out_next;

    assign en        = !ov_reg || !out_stall;
    assign q_pop     = en && !q_empty;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        ptx_next   = q_item.metric_x * q_item.dhy;
        pty_next   = q_item.metric_y * q_item.dhx;
        pkeep_next = q_item.coef_keep * q_item.ez_old;

        // round to nearest, ties up: add half then floor
        tx_sum   = ptx_reg + HALF_P;
        ty_sum   = pty_reg + HALF_P;
        keep_sum = pkeep1_reg + HALF_K;

        curl_diff = (RW+1)'(tx_reg) - (RW+1)'(ty_reg);
        curl_hi   = curl_diff[RW:31];
        curl_clip = !((&curl_hi) || !(|curl_hi));
        if (curl_clip)
        begin
            curl_next = curl_diff[RW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            curl_next = curl_diff[31:0];
        end

        pdrive_next = c2_3_reg * curl_reg;
        drive_sum   = pdrive_reg + HALF_K;

        res_sum = (KW+1)'(keep5_reg) + (KW+1)'(drive_reg);
        res_hi  = res_sum[KW:31];
        if ((&res_hi) || !(|res_hi))
        begin
            out_next.ez_new    = res_sum[31:0];
            out_next.saturated = clip5_reg;
        end
        else
        begin
            out_next.ez_new    = res_sum[KW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            out_next.saturated = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            ov_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ptx_reg    <= ptx_next;
            pty_reg    <= pty_next;
            pkeep1_reg <= pkeep_next;
            c2_1_reg   <= q_item.coef_curl;

            tx_reg    <= tx_sum[PW-1:FRAC_BITS];
            ty_reg    <= ty_sum[PW-1:FRAC_BITS];
            keep2_reg <= keep_sum[63:FRAC_BITS];
            c2_2_reg  <= c2_1_reg;

            curl_reg  <= curl_next;
            clip3_reg <= curl_clip;
            keep3_reg <= keep2_reg;
            c2_3_reg  <= c2_2_reg;

            pdrive_reg <= pdrive_next;
            clip4_reg  <= clip3_reg;
            keep4_reg  <= keep3_reg;

            drive_reg <= drive_sum[63:FRAC_BITS];
            clip5_reg <= clip4_reg;
            keep5_reg <= keep4_reg;

            out_reg <= out_next;
        end
    end

endmodule

@@ sv/fdtd_ez_stencil_update.sv @@
// Channel | Handshake              | Payload
// --------+------------------------+------------------------------------------
// input   | in_valid / in_stall    | in_data  (in_item_t, one grid cell)
// output  | out_valid / out_stall  | out_data (out_item_t, new Ez + clip flag)
// config  | cfg_valid / cfg_ready  | cfg_index (cfg_reg_t), cfg_data
//
// One cell per clock sustained while neither side stalls; a cell's result passes
// through the buffer read stage, the work queue and the six-stage
// multiply/round/saturate pipeline in the back end.
// Halo cells update the Hx/Hy buffers and drop out before the queue.
// Reset clears positions, queue and pipeline valids; buffers are not cleared.
// An output stall freezes the back end; the input stalls only once the queue is full.
module fdtd_ez_stencil_update
    import fez_pkg::*;
#(
    parameter int PLANE_MAX = PLANE_MAX_DEF,
    parameter int ROW_MAX   = ROW_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ROW_LEN_W-1:0]   row_length_reg, row_length_next;
    logic [PLANE_LEN_W-1:0] plane_length_reg, plane_length_next;

    queue_wr_t  q_wr;
    logic       q_push;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    work_item_t q_wr_item;
    work_item_t q_rd_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_length_next   = row_length_reg;
        plane_length_next = plane_length_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROW_LENGTH:   row_length_next   = cfg_data[ROW_LEN_W-1:0];
                CFG_PLANE_LENGTH: plane_length_next = cfg_data[PLANE_LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg   <= ROW_LENGTH_RST;
            plane_length_reg <= PLANE_LENGTH_RST;
        end
        else
        begin
            row_length_reg   <= row_length_next;
            plane_length_reg <= plane_length_next;
        end
    end

    fez_front #(
        .PLANE_MAX (PLANE_MAX),
        .ROW_MAX   (ROW_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .row_length   (row_length_reg),
        .plane_length (plane_length_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_wr_item)
    );

    always_comb
    begin
        q_wr.push = q_push;
        q_wr.full = q_full;
    end

    fez_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_in   (q_wr),
        .full    (q_full),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (q_rd_item)
    );

    fez_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_rd_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
